// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int DataW = 32;
  localparam int PrioW = 16;
  localparam int OccW  = 5;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } spq_ctl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it to the incoming one,
// and shifts toward the tail on insert or toward the front on removal. Uses spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic     clk,
  input  spq_ctl_t ctl,
  input  logic     live,
  input  logic     at_tail,
  input  entry_t   prev_ent,
  input  logic     prev_gt,
  input  entry_t   next_ent,
  output entry_t   ent,
  output logic     gt
);

  entry_t ent_next;

  assign gt = live && (ctl.ent.prio < ent.prio);

  always_comb begin
    ent_next = ent;
    if (ctl.enq) begin
      if (at_tail || gt) begin
        ent_next = prev_gt ? prev_ent : ctl.ent;
      end
    end else if (ctl.deq) begin
      ent_next = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: a chain of DEPTH cells kept in ascending priority order.
// An accepted beat's result is registered into the reply; throughput one beat per cycle
// unless m_tready stalls, set by the single compare-and-shift step of the cell chain.
// Reset clears the occupancy count and the output valid; cell contents stay undefined.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // data_in[31:0], priority_in[47:32]
  input  logic        s_tuser,  // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // data_out[31:0], priority_out[47:32], occupancy[52:48]
  output logic [1:0]  m_tuser   // status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count, count_next;
  logic          accept, full, empty;
  spq_ctl_t      ctl;
  entry_t        ent [DEPTH];
  logic          gt  [DEPTH];

  status_t       status, status_next;
  entry_t        res, res_next;
  logic [CW+4:0] cnt_ext;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  assign ctl.enq      = accept && (cmd_t'(s_tuser) == CMD_ENQ) && !full;
  assign ctl.deq      = accept && (cmd_t'(s_tuser) == CMD_DEQ) && !empty;
  assign ctl.ent.data = s_tdata[31:0];
  assign ctl.ent.prio = s_tdata[47:32];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .live     (count > CW'(i)),
      .at_tail  (count == CW'(i)),
      .prev_ent (ent[(i == 0) ? 0 : i - 1]),
      .prev_gt  ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .next_ent (ent[(i == DEPTH - 1) ? i : i + 1]),
      .ent      (ent[i]),
      .gt       (gt[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    res_next    = '0;
    if (ctl.enq) begin
      count_next = count + 1'b1;
    end else if (ctl.deq) begin
      count_next = count - 1'b1;
      res_next   = ent[0];
    end else if (accept) begin
      status_next = (cmd_t'(s_tuser) == CMD_ENQ) ? ST_OVERFLOW : ST_UNDERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      res    <= res_next;
    end
  end

  assign cnt_ext = {5'd0, count};
  assign m_tdata = {3'd0, cnt_ext[4:0], res.prio, res.data};
  assign m_tuser = status;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for sorted_priority_queue: drives request beats, keeps a
// ranked shadow list of entries, and checks every reply beat field by field.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module testbench;
  import spq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_LEN   = 80;

  typedef struct {
    status_t           status;
    logic [DataW-1:0]  data;
    logic [PrioW-1:0]  prio;
    logic [OccW-1:0]   occ;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // data_in[31:0], priority_in[47:32]
  logic        s_tuser = CMD_ENQ;  // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // data_out[31:0], priority_out[47:32], occupancy[52:48]
  logic [1:0]  m_tuser;        // status

  entry_t ranked_entries[$];
  reply_t owed_replies[$];
  int     failures = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_left = 0;

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hold off for a counted stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void apply_request(cmd_t cmd, logic [DataW-1:0] data,
                                        logic signed [PrioW-1:0] prio);
    reply_t r;
    entry_t e;
    int     pos;
    r.status = ST_OK;
    r.data   = '0;
    r.prio   = '0;
    if (cmd == CMD_ENQ) begin
      if (ranked_entries.size() >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        pos = ranked_entries.size();
        while (pos > 0 && prio < ranked_entries[pos-1].prio) pos--;
        e.data = data;
        e.prio = prio;
        ranked_entries.insert(pos, e);
      end
    end else if (ranked_entries.size() == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      e = ranked_entries.pop_front();
      r.data = e.data;
      r.prio = e.prio;
    end
    r.occ = OccW'(ranked_entries.size());
    owed_replies.push_back(r);
  endfunction

  task automatic send_request(cmd_t cmd, logic [DataW-1:0] data, logic [PrioW-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {prio, data};
    do @(posedge clk); while (!s_tready);
    apply_request(cmd, data, prio);
  endtask

  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t r;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_replies.size() == 0) begin
        $error("reply beat with nothing outstanding: tdata %h tuser %h", m_tdata, m_tuser);
        failures++;
      end else begin
        r = owed_replies.pop_front();
        compare_field("status", 32'(r.status), 32'(m_tuser));
        compare_field("data_out", r.data, m_tdata[31:0]);
        compare_field("priority_out", 32'(r.prio), 32'(m_tdata[47:32]));
        compare_field("occupancy", 32'(r.occ), 32'(m_tdata[52:48]));
      end
    end
  end

  task automatic test_empty_dequeue();
    send_request(CMD_DEQ, 32'hffff_ffff, 16'hffff);
  endtask

  task automatic test_fill_and_overflow();
    logic [PrioW-1:0] prios [16] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0000,
                                     16'h0005, 16'h0005, 16'h0005, 16'hffff,
                                     16'h0001, 16'h7fff, 16'h8000, 16'h0064,
                                     16'h0064, 16'h5555, 16'haaaa, 16'h0002};
    logic [DataW-1:0] datas [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                    32'hffff_ffff};
    for (int i = 0; i < 16; i++)
      send_request(CMD_ENQ, (i < 4) ? datas[i] : 32'h1000_0000 + i, prios[i]);
    send_request(CMD_ENQ, 32'hdead_beef, 16'h8000);
  endtask

  task automatic test_partial_drain();
    repeat (7) send_request(CMD_DEQ, $urandom, 16'($urandom));
  endtask

  task automatic test_random_mix(int items);
    int   enq_pct;
    int   prio_mode;
    cmd_t cmd;
    logic [PrioW-1:0] prio;
    for (int i = 0; i < items; i++) begin
      if (i % 20 == 0) begin
        enq_pct   = 25 * $urandom_range(1, 3);
        prio_mode = $urandom_range(0, 2);
      end
      cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      case (prio_mode)
        0: prio = 16'($urandom_range(0, 6)) - 16'd3;
        1: prio = ($urandom_range(1)) ? 16'h8000 + 16'($urandom_range(3))
                                      : 16'h7fff - 16'($urandom_range(3));
        default: prio = 16'($urandom);
      endcase
      send_request(cmd, $urandom, prio);
    end
  endtask

  task automatic test_backpressure();
    hold_left <= HOLD_LEN;
    for (int i = 0; i < 30; i++)
      send_request((i % 3 == 2) ? CMD_DEQ : CMD_ENQ, $urandom, 16'($urandom));
    wait_for_replies();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 68;
    test_empty_dequeue();
    test_fill_and_overflow();
    test_partial_drain();
    test_random_mix(250);

    send_idle_pct = 68;
    recv_idle_pct = 37;
    test_random_mix(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_mix(220);

    wait_for_replies();
    repeat (4) @(posedge clk);
    if (owed_replies.size() != 0) begin
      $error("%0d replies never arrived", owed_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
